@@ sv/rwsc_pkg.sv @@
// ---------------------------------------------------------------------------
// RSSI window statistics package
// Shared types, widths and constants of the window statistics calibrator.
// ---------------------------------------------------------------------------
package rwsc_pkg;

	localparam int WINDOW_DEF      = 16;
	localparam int CAL_SAMPLES_DEF = 256;

	// Divider widths cover the largest numerator (variance, about 2^38) and
	// the largest divisor (N*(N-1) for a 256-entry window).
	localparam int DIV_NUM_W = 40;
	localparam int DIV_DEN_W = 16;
	localparam int DIV_CNT_W = 6;

	// Running sums sized for the largest window and calibration length.
	localparam int T_W     = 17;
	localparam int S_W     = 23;
	localparam int CSUM_W  = 20;
	localparam int VSUM_W  = 37;

	localparam logic [15:0] ALPHA_RESET    = 16'd655;
	localparam logic [15:0] BASELINE_RESET = 16'hC400;
	localparam logic [23:0] FLOOR_FALLBACK = 24'd13;
	localparam logic [23:0] VAR_MAX        = 24'hFFFFFF;

	typedef enum logic [1:0] {
		OP_SAMPLE     = 2'd0,
		OP_CAL_SAMPLE = 2'd1,
		OP_CAL_START  = 2'd2,
		OP_ADAPT      = 2'd3
	} op_t;

	typedef struct packed {
		op_t                op;
		logic signed [7:0]  rssi;
		logic signed [15:0] mean_in;
	} cmd_t;

	// First member sits in the highest bits.
	typedef struct packed {
		logic [23:0]        noise_floor;
		logic signed [15:0] baseline;
		logic               calibration_done;
		logic               calibrating;
		logic               window_full;
		logic [23:0]        window_variance;
		logic signed [15:0] window_mean;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EXEC,
		ST_EMA,
		ST_PUSH,
		ST_MUL,
		ST_MEAN_GO,
		ST_MEAN_WAIT,
		ST_VAR_GO,
		ST_VAR_WAIT,
		ST_ACC,
		ST_BASE_GO,
		ST_BASE_WAIT,
		ST_FLOOR_GO,
		ST_FLOOR_WAIT,
		ST_EMIT
	} state_t;

endpackage

@@ sv/rwsc_front.sv @@
// ---------------------------------------------------------------------------
// RSSI window statistics front end
// Accepts input transactions, decodes the opcode and hands commands on.
// ---------------------------------------------------------------------------
module rwsc_front import rwsc_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         in_opcode,
	input  logic signed [7:0]  in_rssi,
	input  logic signed [15:0] in_mean,
	output logic               cmd_valid,
	input  logic               cmd_ready,
	output cmd_t               cmd
);

	logic valid_s1;
	cmd_t cmd_s1;

	assign in_ready  = !valid_s1 || cmd_ready;
	assign cmd_valid = valid_s1;
	assign cmd       = cmd_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			cmd_s1.op      <= op_t'(in_opcode);
			cmd_s1.rssi    <= in_rssi;
			cmd_s1.mean_in <= in_mean;
		end
	end

endmodule

@@ sv/rwsc_queue.sv @@
// ---------------------------------------------------------------------------
// RSSI window statistics command queue
// Two-entry queue between the front end and the execution sequencer.
// ---------------------------------------------------------------------------
module rwsc_queue import rwsc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  cmd_t in_cmd,
	output logic out_valid,
	input  logic out_ready,
	output cmd_t out_cmd
);

	cmd_t       entry_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	logic       push;
	logic       pop;

	assign in_ready  = (count_q != 2'd2);
	assign out_valid = (count_q != 2'd0);
	assign out_cmd   = entry_q[rd_ptr_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop) rd_ptr_q <= !rd_ptr_q;
			count_q <= count_q + {1'b0, push} - {1'b0, pop};
		end
	end

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= in_cmd;
	end

endmodule

@@ sv/rwsc_div.sv @@
// ---------------------------------------------------------------------------
// RSSI window statistics divider
// Unsigned restoring divider, one quotient bit per cycle.
// ---------------------------------------------------------------------------
module rwsc_div import rwsc_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic [DIV_NUM_W-1:0] num,
	input  logic [DIV_DEN_W-1:0] den,
	output logic                 busy,
	output logic                 done,
	output logic [DIV_NUM_W-1:0] quo
);

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [DIV_DEN_W-1:0] rem_q;
	logic [DIV_DEN_W-1:0] den_q;
	logic [DIV_NUM_W-1:0] quo_q;
	logic [DIV_DEN_W:0]   trial;
	logic                 fits;

	assign trial = {rem_q, quo_q[DIV_NUM_W-1]};
	assign fits  = (trial >= {1'b0, den_q});
	assign busy  = busy_q;
	assign done  = done_q;
	assign quo   = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= DIV_CNT_W'(DIV_NUM_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			den_q <= den;
			quo_q <= num;
		end else if (busy_q) begin
			rem_q <= fits ? DIV_DEN_W'(trial - {1'b0, den_q}) : trial[DIV_DEN_W-1:0];
			quo_q <= {quo_q[DIV_NUM_W-2:0], fits};
		end
	end

endmodule

@@ sv/rwsc_back.sv @@
// ---------------------------------------------------------------------------
// RSSI window statistics sequencer
// Executes commands on the sample window and calibration state.
// ---------------------------------------------------------------------------
module rwsc_back import rwsc_pkg::*; #(
	parameter int WINDOW      = WINDOW_DEF,
	parameter int CAL_SAMPLES = CAL_SAMPLES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [15:0] alpha,
	input  logic        cmd_valid,
	output logic        cmd_ready,
	input  cmd_t        cmd,
	output logic        out_valid,
	input  logic        out_ready,
	output result_t     out_res
);

	localparam int PTR_W  = $clog2(WINDOW);
	localparam int FILL_W = $clog2(WINDOW + 1);
	localparam int CCNT_W = $clog2(CAL_SAMPLES + 1);

	state_t state_q, state_d;
	cmd_t   cmd_q;

	logic signed [7:0] win_mem [WINDOW];
	logic signed [7:0] old_q;

	logic [PTR_W-1:0]  wptr_q;
	logic [FILL_W-1:0] fill_q;
	logic signed [T_W-1:0] t_q;
	logic [S_W-1:0]        s_q;

	logic                     cal_q;
	logic                     hit_q;
	logic                     done_q;
	logic [CCNT_W-1:0]        ccnt_q;
	logic signed [CSUM_W-1:0] csum_q;
	logic [VSUM_W-1:0]        vsum_q;
	logic [CCNT_W-1:0]        vcnt_q;
	logic signed [15:0]       base_q;
	logic [23:0]              floor_q;

	logic signed [34:0] pb_q;
	logic signed [34:0] pm_q;
	logic [31:0]        ns_q;
	logic [33:0]        tt_q;
	logic [DIV_DEN_W-1:0] nn_q;
	logic signed [15:0] mean_q;
	logic [23:0]        var_q;

	logic               out_valid_q;
	result_t            out_res_q;

	logic                 div_start;
	logic [DIV_NUM_W-1:0] div_num;
	logic [DIV_DEN_W-1:0] div_den;
	logic                 div_busy;
	logic                 div_done;
	logic [DIV_NUM_W-1:0] div_quo;

	logic                     full;
	logic                     out_free;
	logic [16:0]              wb;
	logic signed [15:0]       xsq;
	logic signed [15:0]       osq;
	logic signed [2*T_W-1:0]  tt_full;
	logic [T_W-1:0]           t_abs;
	logic [CSUM_W-1:0]        c_abs;
	logic [33:0]              diff;
	logic signed [34:0]       ema;
	logic [16:0]              mq;

	assign full     = (fill_q == FILL_W'(WINDOW));
	assign out_free = !out_valid_q || out_ready;
	assign wb       = 17'h10000 - {1'b0, alpha};
	assign xsq      = cmd_q.rssi * cmd_q.rssi;
	assign osq      = old_q * old_q;
	assign tt_full  = t_q * t_q;
	assign t_abs    = t_q[T_W-1] ? T_W'(-t_q) : T_W'(t_q);
	assign c_abs    = csum_q[CSUM_W-1] ? CSUM_W'(-csum_q) : CSUM_W'(csum_q);
	assign diff     = {2'b00, ns_q} - tt_q;
	assign ema      = pb_q + pm_q + 35'sd32768;
	assign mq       = div_quo[16:0];

	assign cmd_ready = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_res   = out_res_q;

	rwsc_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (div_busy),
		.done   (div_done),
		.quo    (div_quo)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: if (cmd_valid) state_d = ST_EXEC;
			ST_EXEC: begin
				case (cmd_q.op)
					OP_SAMPLE:     state_d = ST_PUSH;
					OP_CAL_SAMPLE: state_d = cal_q ? ST_PUSH : ST_MUL;
					OP_ADAPT:      state_d = cal_q ? ST_MUL : ST_EMA;
					default:       state_d = ST_MUL;
				endcase
			end
			ST_EMA:       state_d = ST_MUL;
			ST_PUSH:      state_d = ST_MUL;
			ST_MUL:       state_d = ST_MEAN_GO;
			ST_MEAN_GO:   state_d = (fill_q == '0) ? ST_VAR_GO : ST_MEAN_WAIT;
			ST_MEAN_WAIT: if (div_done) state_d = ST_VAR_GO;
			ST_VAR_GO:    state_d = (fill_q < FILL_W'(2)) ? ST_ACC : ST_VAR_WAIT;
			ST_VAR_WAIT:  if (div_done) state_d = ST_ACC;
			ST_ACC: begin
				if (hit_q && ccnt_q >= CCNT_W'(CAL_SAMPLES)) state_d = ST_BASE_GO;
				else state_d = ST_EMIT;
			end
			ST_BASE_GO:    state_d = ST_BASE_WAIT;
			ST_BASE_WAIT:  if (div_done) state_d = ST_FLOOR_GO;
			ST_FLOOR_GO:   state_d = (vcnt_q == '0) ? ST_EMIT : ST_FLOOR_WAIT;
			ST_FLOOR_WAIT: if (div_done) state_d = ST_EMIT;
			ST_EMIT:       if (out_free) state_d = ST_IDLE;
			default:       state_d = ST_IDLE;
		endcase
	end

	// Divider operands.
	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		case (state_q)
			ST_MEAN_GO: begin
				div_start = (fill_q != '0);
				div_num   = (DIV_NUM_W'(t_abs) << 8) + DIV_NUM_W'(fill_q >> 1);
				div_den   = DIV_DEN_W'(fill_q);
			end
			ST_VAR_GO: begin
				div_start = (fill_q >= FILL_W'(2));
				div_num   = {diff[31:0], 8'h00} + DIV_NUM_W'(nn_q >> 1);
				div_den   = nn_q;
			end
			ST_BASE_GO: begin
				div_start = 1'b1;
				div_num   = (DIV_NUM_W'(c_abs) << 8) + DIV_NUM_W'(ccnt_q >> 1);
				div_den   = DIV_DEN_W'(ccnt_q);
			end
			ST_FLOOR_GO: begin
				div_start = (vcnt_q != '0);
				div_num   = DIV_NUM_W'(vsum_q) + DIV_NUM_W'(vcnt_q >> 1);
				div_den   = DIV_DEN_W'(vcnt_q);
			end
			default: begin
				div_start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		old_q <= win_mem[wptr_q];
		if (state_q == ST_PUSH) win_mem[wptr_q] <= cmd_q.rssi;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			wptr_q      <= '0;
			fill_q      <= '0;
			t_q         <= '0;
			s_q         <= '0;
			cal_q       <= 1'b0;
			hit_q       <= 1'b0;
			done_q      <= 1'b0;
			ccnt_q      <= '0;
			csum_q      <= '0;
			vsum_q      <= '0;
			vcnt_q      <= '0;
			base_q      <= BASELINE_RESET;
			floor_q     <= FLOOR_FALLBACK;
			mean_q      <= '0;
			var_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_EMIT && out_free) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
			case (state_q)
				ST_EXEC: begin
					done_q <= 1'b0;
					hit_q  <= (cmd_q.op == OP_CAL_SAMPLE) && cal_q;
					if (cmd_q.op == OP_CAL_START) begin
						cal_q  <= 1'b1;
						ccnt_q <= '0;
						csum_q <= '0;
						vsum_q <= '0;
						vcnt_q <= '0;
						fill_q <= '0;
						wptr_q <= '0;
						t_q    <= '0;
						s_q    <= '0;
					end
				end
				ST_EMA: base_q <= ema[31:16];
				ST_PUSH: begin
					wptr_q <= (wptr_q == PTR_W'(WINDOW - 1)) ? '0 : wptr_q + 1'b1;
					if (!full) fill_q <= fill_q + 1'b1;
					t_q <= t_q + T_W'(cmd_q.rssi) - (full ? T_W'(old_q) : '0);
					s_q <= s_q + S_W'(xsq) - (full ? S_W'(osq) : '0);
					if (hit_q) begin
						ccnt_q <= ccnt_q + 1'b1;
						csum_q <= csum_q + CSUM_W'(cmd_q.rssi);
					end
				end
				ST_MEAN_GO: if (fill_q == '0) mean_q <= '0;
				ST_MEAN_WAIT: if (div_done) mean_q <= t_q[T_W-1] ? 16'(-mq) : 16'(mq);
				ST_VAR_GO: if (fill_q < FILL_W'(2)) var_q <= '0;
				ST_VAR_WAIT: begin
					if (div_done) var_q <= (div_quo > DIV_NUM_W'(VAR_MAX)) ? VAR_MAX : div_quo[23:0];
				end
				ST_ACC: begin
					if (hit_q && full) begin
						vsum_q <= vsum_q + VSUM_W'(var_q);
						vcnt_q <= vcnt_q + 1'b1;
					end
					if (hit_q && ccnt_q >= CCNT_W'(CAL_SAMPLES)) begin
						cal_q  <= 1'b0;
						done_q <= 1'b1;
					end
				end
				ST_BASE_WAIT: begin
					if (div_done) base_q <= csum_q[CSUM_W-1] ? 16'(-div_quo) : div_quo[15:0];
				end
				ST_FLOOR_GO: if (vcnt_q == '0) floor_q <= FLOOR_FALLBACK;
				ST_FLOOR_WAIT: begin
					if (div_done) begin
						if (div_quo > DIV_NUM_W'(VAR_MAX)) floor_q <= VAR_MAX;
						else if (div_quo == '0) floor_q <= 24'd1;
						else floor_q <= div_quo[23:0];
					end
				end
				default: begin
					hit_q <= hit_q;
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && cmd_valid) cmd_q <= cmd;
		if (state_q == ST_EXEC) begin
			pb_q <= $signed({1'b0, wb}) * base_q;
			pm_q <= $signed({1'b0, alpha}) * cmd_q.mean_in;
		end
		if (state_q == ST_MUL) begin
			ns_q <= 32'(fill_q) * 32'(s_q);
			tt_q <= tt_full[33:0];
			nn_q <= DIV_DEN_W'(fill_q) * DIV_DEN_W'(fill_q - 1'b1);
		end
		if (state_q == ST_EMIT && out_free) begin
			out_res_q.window_mean      <= mean_q;
			out_res_q.window_variance  <= var_q;
			out_res_q.window_full      <= full;
			out_res_q.calibrating      <= cal_q;
			out_res_q.calibration_done <= done_q;
			out_res_q.baseline         <= base_q;
			out_res_q.noise_floor      <= floor_q;
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(WINDOW))
		else $error("fill count beyond window depth");

	a_div_wait: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == ST_MEAN_WAIT || state_q == ST_VAR_WAIT ||
			state_q == ST_BASE_WAIT || state_q == ST_FLOOR_WAIT))
		else $error("divider finished outside a wait state");

	a_div_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		div_start |-> !div_busy)
		else $error("divider started while busy");

	a_done_ends_cal: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT && done_q) |-> !cal_q)
		else $error("calibration done reported while still calibrating");

endmodule

@@ sv/rssi_window_stats_calibrator.sv @@
// ---------------------------------------------------------------------------
// RSSI window statistics calibrator
// Sliding-window mean and variance of RSSI samples with a calibrated
// baseline and noise floor.
// ---------------------------------------------------------------------------
// Every input transaction yields exactly one output transaction carrying the
// window mean (signed Q8.8), the N-1 sample variance (unsigned Q16.8), the
// window and calibration flags, the baseline (signed Q8.8) and the noise
// floor (unsigned Q16.8), all as they stand after the item is applied. The
// time is set by the shared divider, which produces one quotient bit per
// cycle over 40 bits while it is busy. An item needs a division for the mean
// and one for the variance once the window holds two or more samples; with
// one sample the variance division is skipped, and with none the mean
// division too. The calibration sample that ends calibration adds the
// baseline and floor averages, and skips the floor division when no
// full-window variance was gathered. A two-entry queue and an input register
// take further items while one is in work, and a finished result waits in
// the output register while the next item is worked on.
// The EMA weight register may be written only while the block is idle.
// ---------------------------------------------------------------------------
module rssi_window_stats_calibrator import rwsc_pkg::*; #(
	parameter int WINDOW      = WINDOW_DEF,
	parameter int CAL_SAMPLES = CAL_SAMPLES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// EMA weight of the new mean, unsigned Q0.16
	input  logic        cfg_we,
	input  logic [15:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// [7:0] rssi, [23:8] mean_in
	input  logic [23:0] s_axis_tdata,
	// [1:0] opcode
	input  logic [1:0]  s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [15:0] window_mean, [39:16] window_variance, [40] window_full,
	// [41] calibrating, [42] calibration_done, [58:43] baseline,
	// [82:59] noise_floor, [87:83] zero
	output logic [87:0] m_axis_tdata
);

	logic [15:0] alpha_q;
	logic        cmd_valid;
	logic        cmd_ready;
	cmd_t        cmd;
	logic        q_valid;
	logic        q_ready;
	cmd_t        q_cmd;
	result_t     res;

	// The EMA weight is held here and used by the sequencer directly.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alpha_q <= ALPHA_RESET;
		end else if (cfg_we) begin
			alpha_q <= cfg_wdata;
		end
	end

	// The front end registers and decodes each incoming transaction.
	rwsc_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_opcode (s_axis_tuser),
		.in_rssi   (s_axis_tdata[7:0]),
		.in_mean   (s_axis_tdata[23:8]),
		.cmd_valid (cmd_valid),
		.cmd_ready (cmd_ready),
		.cmd       (cmd)
	);

	// Commands wait here so that either side can stall on its own.
	rwsc_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (cmd_valid),
		.in_ready  (cmd_ready),
		.in_cmd    (cmd),
		.out_valid (q_valid),
		.out_ready (q_ready),
		.out_cmd   (q_cmd)
	);

	// The sequencer owns the window memory, the running sums, calibration
	// and the output register.
	rwsc_back #(
		.WINDOW      (WINDOW),
		.CAL_SAMPLES (CAL_SAMPLES)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.alpha     (alpha_q),
		.cmd_valid (q_valid),
		.cmd_ready (q_ready),
		.cmd       (q_cmd),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (res)
	);

	assign m_axis_tdata = {5'b00000, res};

endmodule

@@ sim/tb_top.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// RSSI window statistics calibrator testbench
// Streams opcode transactions into the block under random bursts and output
// stalls, predicts each result from an internal model of the window, the
// calibration accumulators and the baseline filter, and compares every field.
// ---------------------------------------------------------------------------
module tb_top;
	import rwsc_pkg::*;

	localparam int WIN = WINDOW_DEF;
	localparam int CAL_N = CAL_SAMPLES_DEF;

	typedef struct {
		op_t               op;
		logic signed [7:0] rssi;
		logic signed [15:0] mean_in;
	} stim_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [15:0] cfg_wdata;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [23:0] s_axis_tdata;
	logic [1:0]  s_axis_tuser;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [87:0] m_axis_tdata;

	rssi_window_stats_calibrator u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	// Predictor state.
	logic signed [7:0] win_q [WIN];
	int        wr_ptr, fill_n;
	bit        cal_on;
	int        cal_cnt, cal_var_cnt;
	longint    cal_sum;
	longint unsigned cal_var_sum;
	longint    base_q;
	longint unsigned floor_q;
	longint unsigned alpha_q;

	stim_t   pending_q[$];
	result_t expected_q[$];
	int      fail_count = 0;
	int      n_done = 0, n_results = 0;

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	function automatic longint rnd_away(longint num, longint den);
		if (num >= 0) return (num + den / 2) / den;
		return -((-num + den / 2) / den);
	endfunction

	function automatic longint win_mean();
		longint s = 0;
		if (fill_n == 0) return 0;
		for (int i = 0; i < fill_n; i++) s += win_q[i];
		return rnd_away(s * 256, fill_n);
	endfunction

	function automatic longint unsigned win_var();
		longint t = 0, sq = 0;
		longint unsigned num, den, v;
		if (fill_n < 2) return 0;
		for (int i = 0; i < fill_n; i++) begin
			t += win_q[i];
			sq += longint'(win_q[i]) * win_q[i];
		end
		num = longint'(fill_n * sq - t * t) * 256;
		den = fill_n * (fill_n - 1);
		v = (num + den / 2) / den;
		return (v > 64'hFFFFFF) ? 64'hFFFFFF : v;
	endfunction

	function automatic void push_rssi(logic signed [7:0] x);
		win_q[wr_ptr] = x;
		wr_ptr = (wr_ptr + 1) % WIN;
		if (fill_n < WIN) fill_n++;
	endfunction

	// Applies one transaction to the predictor and returns the expected result.
	function automatic result_t stats_predict(stim_t it);
		result_t r;
		bit done = 0;
		longint p;
		longint unsigned f;
		case (it.op)
			OP_SAMPLE: push_rssi(it.rssi);
			OP_CAL_SAMPLE: if (cal_on) begin
				push_rssi(it.rssi);
				cal_cnt++;
				cal_sum += it.rssi;
				if (fill_n >= WIN) begin
					cal_var_sum += win_var();
					cal_var_cnt++;
				end
				if (cal_cnt >= CAL_N) begin
					cal_on = 0;
					done = 1;
					base_q = rnd_away(cal_sum * 256, cal_cnt);
					if (cal_var_cnt > 0) begin
						f = (cal_var_sum + cal_var_cnt / 2) / cal_var_cnt;
						floor_q = (f > 64'hFFFFFF) ? 64'hFFFFFF : f;
					end else
						floor_q = 13;
					if (floor_q < 1) floor_q = 1;
				end
			end
			OP_CAL_START: begin
				cal_on = 1;
				cal_cnt = 0;
				cal_sum = 0;
				cal_var_sum = 0;
				cal_var_cnt = 0;
				fill_n = 0;
				wr_ptr = 0;
			end
			OP_ADAPT: if (!cal_on) begin
				p = (65536 - longint'(alpha_q)) * base_q
					+ longint'(alpha_q) * longint'(it.mean_in) + 32768;
				base_q = (p >= 0) ? p / 65536 : -((-p + 65535) / 65536);
			end
		endcase
		r.window_mean      = 16'(win_mean());
		r.window_variance  = 24'(win_var());
		r.window_full      = (fill_n >= WIN);
		r.calibrating      = cal_on;
		r.calibration_done = done;
		r.baseline         = 16'(base_q);
		r.noise_floor      = 24'(floor_q);
		return r;
	endfunction

	// Driver: bursts of random length separated by random gaps.
	int burst_left = 0, gap_left = 0;
	always @(posedge clk or negedge arst_n) begin
		stim_t it;
		if (!arst_n) begin
			s_axis_tvalid <= 0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= '0;
		end else begin
			if (s_axis_tvalid && s_axis_tready) begin
				expected_q.push_back(stats_predict(pending_q.pop_front()));
				n_done++;
			end
			if (!(s_axis_tvalid && !s_axis_tready)) begin
				if (gap_left > 0) begin
					gap_left--;
					s_axis_tvalid <= 0;
				end else if (pending_q.size() > 0) begin
					it = pending_q[0];
					s_axis_tvalid <= 1;
					s_axis_tdata  <= {it.mean_in, it.rssi};
					s_axis_tuser  <= it.op;
					if (burst_left > 0) burst_left--;
					else begin
						burst_left = $urandom_range(0, 12);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 150);
					end
				end else
					s_axis_tvalid <= 0;
			end
		end
	end

	// Receiver stall pattern and result checker.
	int stall_phase = 0;
	always @(posedge clk or negedge arst_n) begin
		result_t got, exp_r;
		if (!arst_n) begin
			m_axis_tready <= 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got = result_t'(m_axis_tdata[82:0]);
				n_results++;
				if (expected_q.size() == 0) begin
					$error("result transaction with nothing expected");
					fail_count++;
				end else begin
					exp_r = expected_q.pop_front();
					if (got.window_mean !== exp_r.window_mean) begin
						$error("window_mean exp %0d got %0d", exp_r.window_mean,
							got.window_mean);
						fail_count++;
					end
					if (got.window_variance !== exp_r.window_variance) begin
						$error("window_variance exp %0d got %0d",
							exp_r.window_variance, got.window_variance);
						fail_count++;
					end
					if (got.window_full !== exp_r.window_full) begin
						$error("window_full exp %0d got %0d", exp_r.window_full,
							got.window_full);
						fail_count++;
					end
					if (got.calibrating !== exp_r.calibrating) begin
						$error("calibrating exp %0d got %0d", exp_r.calibrating,
							got.calibrating);
						fail_count++;
					end
					if (got.calibration_done !== exp_r.calibration_done) begin
						$error("calibration_done exp %0d got %0d",
							exp_r.calibration_done, got.calibration_done);
						fail_count++;
					end
					if (got.baseline !== exp_r.baseline) begin
						$error("baseline exp %0d got %0d", exp_r.baseline, got.baseline);
						fail_count++;
					end
					if (got.noise_floor !== exp_r.noise_floor) begin
						$error("noise_floor exp %0d got %0d", exp_r.noise_floor,
							got.noise_floor);
						fail_count++;
					end
				end
			end
			// Long stretches of ready, then windows of random stalls.
			stall_phase = (stall_phase + 1) % 2000;
			if (stall_phase < 700) m_axis_tready <= 1;
			else m_axis_tready <= ($urandom_range(0, 3) == 0);
		end
	end

	function automatic stim_t mk(op_t op, int r, int m);
		stim_t it;
		it.op = op;
		it.rssi = 8'(r);
		it.mean_in = 16'(m);
		return it;
	endfunction

	task automatic wait_drained();
		while (pending_q.size() > 0 || expected_q.size() > 0 || s_axis_tvalid)
			@(posedge clk);
		repeat (400) @(posedge clk);
	endtask

	task automatic write_alpha(logic [15:0] a);
		@(posedge clk);
		cfg_we    <= 1;
		cfg_wdata <= a;
		alpha_q   = a;
		@(posedge clk);
		cfg_we    <= 0;
	endtask

	// One calibration run: start, then n calibration samples near a level,
	// with plain samples and adapts mixed in.
	task automatic queue_cal(int lvl, int spread, int n);
		pending_q.push_back(mk(OP_CAL_START, 0, 0));
		for (int i = 0; i < n; i++) begin
			int r;
			r = lvl + $urandom_range(0, 2 * spread) - spread;
			if (r > 127) r = 127;
			if (r < -128) r = -128;
			if ($urandom_range(0, 15) == 0)
				pending_q.push_back(mk(OP_ADAPT, 0, $urandom_range(0, 65535)));
			if ($urandom_range(0, 15) == 0)
				pending_q.push_back(mk(OP_SAMPLE, $urandom_range(0, 255), 0));
			pending_q.push_back(mk(OP_CAL_SAMPLE, r, 0));
		end
	endtask

	task automatic queue_random(int n);
		for (int i = 0; i < n; i++) begin
			int k;
			k = $urandom_range(0, 19);
			if (k < 12) pending_q.push_back(mk(OP_SAMPLE, $urandom_range(0, 255), 0));
			else if (k < 15)
				pending_q.push_back(mk(OP_ADAPT, 0, $urandom_range(0, 65535)));
			else if (k < 19)
				pending_q.push_back(mk(OP_CAL_SAMPLE, $urandom_range(0, 255), 0));
			else pending_q.push_back(mk(OP_CAL_START, 0, 0));
		end
	endtask

	initial begin
		for (int i = 0; i < WIN; i++) win_q[i] = 0;
		wr_ptr = 0; fill_n = 0; cal_on = 0; cal_cnt = 0; cal_var_cnt = 0;
		cal_sum = 0; cal_var_sum = 0;
		base_q = -15360; floor_q = 13; alpha_q = 655;
		arst_n = 0; cfg_we = 0; cfg_wdata = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// Directed: empty window, single sample, idle calibration sample,
		// extremes, full window with maximum spread, adapt extremes.
		pending_q.push_back(mk(OP_CAL_SAMPLE, 5, 0));
		pending_q.push_back(mk(OP_ADAPT, 0, 32767));
		pending_q.push_back(mk(OP_SAMPLE, -128, 0));
		pending_q.push_back(mk(OP_SAMPLE, 127, 0));
		for (int i = 0; i < 16; i++)
			pending_q.push_back(mk(OP_SAMPLE, (i % 2) ? 127 : -128, 0));
		pending_q.push_back(mk(OP_ADAPT, 0, -32768));
		pending_q.push_back(mk(OP_CAL_START, 0, 0));
		pending_q.push_back(mk(OP_ADAPT, 0, 1000));
		pending_q.push_back(mk(OP_CAL_START, 0, 0));
		wait_drained();

		// Extreme alphas with adapts.
		write_alpha(16'hFFFF);
		pending_q.push_back(mk(OP_CAL_SAMPLE, 0, 0));
		queue_cal(-70, 0, CAL_N);
		for (int i = 0; i < 6; i++)
			pending_q.push_back(mk(OP_ADAPT, 0, $urandom_range(0, 65535)));
		wait_drained();
		write_alpha(16'h0000);
		for (int i = 0; i < 6; i++)
			pending_q.push_back(mk(OP_ADAPT, 0, $urandom_range(0, 65535)));
		// Calibration with too few samples to fill the window never happens
		// at this length, so check the full-scale spread case instead.
		queue_cal(0, 128, CAL_N);
		wait_drained();
		write_alpha(16'($urandom_range(1, 65534)));
		queue_random(120);
		queue_cal(-50, 6, CAL_N);
		queue_random(50);
		wait_drained();
		write_alpha(ALPHA_RESET);
		queue_random(40);
		wait_drained();

		$display("Covered %0d transactions and %0d results, including three full",
			n_done, n_results);
		$display("calibrations and baseline filter weights at both extremes.");
		if (fail_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	initial begin
		#60ms;
		$display("Regression FAIL");
		$finish;
	end
endmodule
